// ----- rtl/best_fit_lifetime_buffer_planner_macros.svh -----
// Assertion macros used by the checker file of the planner.
`ifndef BEST_FIT_LIFETIME_BUFFER_PLANNER_MACROS_SVH
`define BEST_FIT_LIFETIME_BUFFER_PLANNER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BFL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bfl_pkg.sv -----
// Package of the best-fit buffer planner: field widths, defaults, shared types.
`default_nettype none

package bfl_pkg;

    localparam int IDX_W  = 8;
    localparam int SIZE_W = 31;
    localparam int STEP_W = 16;
    localparam int OFS_W  = 39;
    localparam int NEED_W = 32;

    localparam int POOL_DEPTH_DEF  = 256;
    localparam int ALIGN_BYTES_DEF = 64;

    typedef struct packed {
        logic [OFS_W-1:0]  ofs;
        logic [NEED_W-1:0] size;
        logic [STEP_W-1:0] freed;
    } slot_t;

    typedef struct packed {
        logic clear;
        logic issue;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/bfl_if.sv -----
// Valid/ready channel interfaces for lifetime items and placement results.
`default_nettype none

interface bfl_in_if;
    logic                          valid;
    logic                          ready;
    logic                          start_plan;
    logic [bfl_pkg::IDX_W-1:0]     tensor_index;
    logic [bfl_pkg::SIZE_W-1:0]    byte_count;
    logic [bfl_pkg::STEP_W-1:0]    first_step;
    logic [bfl_pkg::STEP_W-1:0]    last_step;

    modport source (
        output valid, start_plan, tensor_index, byte_count, first_step, last_step,
        input  ready
    );
    modport sink (
        input  valid, start_plan, tensor_index, byte_count, first_step, last_step,
        output ready
    );
endinterface

interface bfl_out_if;
    logic                          valid;
    logic                          ready;
    logic [bfl_pkg::IDX_W-1:0]     out_tensor_index;
    logic [bfl_pkg::OFS_W-1:0]     offset;
    logic                          reused;
    logic [bfl_pkg::OFS_W-1:0]     region_bytes;
    logic                          rejected;

    modport source (
        output valid, out_tensor_index, offset, reused, region_bytes, rejected,
        input  ready
    );
    modport sink (
        input  valid, out_tensor_index, offset, reused, region_bytes, rejected,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/best_fit_lifetime_buffer_planner.sv -----
// Top level of the best-fit lifetime buffer planner.
//
// Channels: lifetime (sink) takes one buffer per transfer: start_plan,
// tensor_index, byte_count, first_step, last_step, in order of first use.
// placement (source) returns one result per item: out_tensor_index, offset,
// reused, region_bytes, rejected.
// The result comes from the alignment unit, the pool scan with one read of
// the slot memory per cycle over the N slots in the pool (at most POOL_DEPTH),
// and the decision; a reuse adds a memory move and a write of the new slot.
// One item is in work at a time; ready is high only when the planner is
// between items, so no item is taken before the previous one is finished.
// The result sits in an output register, so the next item is taken while
// a result waits; if the receiver stalls, the planner finishes that item
// and holds it until the output register frees up.
// Reset empties the pool and zeroes the high-water mark; the slot memory
// needs no clearing pass, since only entries below the slot count are read.
// start_plan=1 on an item does the same before that item is planned.
`default_nettype none

module best_fit_lifetime_buffer_planner #(
    parameter int POOL_DEPTH  = bfl_pkg::POOL_DEPTH_DEF,
    parameter int ALIGN_BYTES = bfl_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bfl_in_if.sink     lifetime,
    bfl_out_if.source  placement
);

    localparam int AW    = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int OFS_W = bfl_pkg::OFS_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ALIGN  = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_MOVE   = 7'b0010000,
        ST_PLACE  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [OFS_W-1:0]              hw_reg, hw_next;
    logic [CNT_W-1:0]              p_reg, p_next;
    logic [bfl_pkg::IDX_W-1:0]     tidx_reg;
    logic [bfl_pkg::STEP_W-1:0]    first_reg;
    logic [bfl_pkg::STEP_W-1:0]    last_reg;
    logic [bfl_pkg::NEED_W-1:0]    need_reg;
    logic [OFS_W-1:0]              res_ofs_reg, res_ofs_next;
    logic                          res_reused_reg, res_reused_next;
    logic                          res_rej_reg, res_rej_next;
    logic [OFS_W-1:0]              res_hw_reg, res_hw_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bfl_pkg::IDX_W-1:0]     out_tidx_reg;
    logic [OFS_W-1:0]              out_ofs_reg;
    logic                          out_reused_reg;
    logic [OFS_W-1:0]              out_hw_reg;
    logic                          out_rej_reg;

    logic                          accept;
    logic                          out_load;
    logic                          align_done;
    logic [bfl_pkg::NEED_W-1:0]    align_need;
    bfl_pkg::scan_ctl_t            scan_ctl;
    logic                          found;
    logic [AW-1:0]                 best_idx;
    logic [OFS_W-1:0]              best_ofs;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    bfl_pkg::slot_t                mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    bfl_pkg::slot_t                mem_rdata;
    logic [OFS_W:0]                hw_sum;
    logic                          pool_full;
    logic                          reject;
    logic [CNT_W-1:0]              last_slot;

    assign accept   = lifetime.valid && lifetime.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || placement.ready);

    assign hw_sum    = {1'b0, hw_reg} + (OFS_W + 1)'(need_reg);
    assign pool_full = (count_reg >= CNT_W'(POOL_DEPTH));
    assign reject    = !found && (pool_full || hw_sum[OFS_W]);
    assign last_slot = count_reg - 1'b1;

    bfl_align #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .size  (lifetime.byte_count),
        .done  (align_done),
        .need  (align_need)
    );

    bfl_pool_mem #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfl_best_sel #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .raddr      (mem_raddr),
        .rdata      (mem_rdata),
        .need       (need_reg),
        .first_step (first_reg),
        .found      (found),
        .best_idx   (best_idx),
        .best_ofs   (best_ofs)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        p_next          = p_reg;
        res_ofs_next    = res_ofs_reg;
        res_reused_next = res_reused_reg;
        res_rej_next    = res_rej_reg;
        res_hw_next     = res_hw_reg;
        scan_ctl        = '0;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = '{ofs: hw_reg, size: need_reg, freed: last_reg};
        mem_re          = 1'b0;
        mem_raddr       = p_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_next     = '0;
                    state_next = ST_ALIGN;
                    if (lifetime.start_plan)
                    begin
                        count_next = '0;
                        hw_next    = '0;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (align_done)
                begin
                    scan_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue one pool read per cycle; the tracker sees it in the following cycle
                if (p_reg < count_reg)
                begin
                    scan_ctl.issue = 1'b1;
                    mem_re         = 1'b1;
                    p_next         = p_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_hw_next = hw_reg;
                if (found)
                begin
                    // Fetch the last slot to fill the hole left by the reused one
                    mem_re          = 1'b1;
                    mem_raddr       = last_slot[AW-1:0];
                    res_ofs_next    = best_ofs;
                    res_reused_next = 1'b1;
                    res_rej_next    = 1'b0;
                    state_next      = ST_MOVE;
                end
                else if (reject)
                begin
                    res_ofs_next    = '0;
                    res_reused_next = 1'b0;
                    res_rej_next    = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    hw_next         = hw_sum[OFS_W-1:0];
                    res_ofs_next    = hw_reg;
                    res_reused_next = 1'b0;
                    res_rej_next    = 1'b0;
                    res_hw_next     = hw_sum[OFS_W-1:0];
                    state_next      = ST_DONE;
                end
            end
            ST_MOVE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_idx;
                mem_wdata  = mem_rdata;
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = last_slot[AW-1:0];
                mem_wdata  = '{ofs: best_ofs, size: need_reg, freed: last_reg};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (placement.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            hw_reg        <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hw_reg        <= hw_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tidx_reg  <= lifetime.tensor_index;
            first_reg <= lifetime.first_step;
            last_reg  <= lifetime.last_step;
        end
        if (align_done)
        begin
            need_reg <= align_need;
        end
        res_ofs_reg    <= res_ofs_next;
        res_reused_reg <= res_reused_next;
        res_rej_reg    <= res_rej_next;
        res_hw_reg     <= res_hw_next;
        if (out_load)
        begin
            out_tidx_reg   <= tidx_reg;
            out_ofs_reg    <= res_ofs_reg;
            out_reused_reg <= res_reused_reg;
            out_hw_reg     <= res_hw_reg;
            out_rej_reg    <= res_rej_reg;
        end
    end

    assign lifetime.ready             = (state_reg == ST_IDLE);
    assign placement.valid            = out_valid_reg;
    assign placement.out_tensor_index = out_tidx_reg;
    assign placement.offset           = out_ofs_reg;
    assign placement.reused           = out_reused_reg;
    assign placement.region_bytes     = out_hw_reg;
    assign placement.rejected         = out_rej_reg;

endmodule

`default_nettype wire

// ----- rtl/bfl_align.sv -----
// Multi-cycle unit that rounds a size up to a multiple of the alignment.
`default_nettype none

module bfl_align #(
    parameter int ALIGN_BYTES = bfl_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bfl_pkg::SIZE_W-1:0]  size,
    output logic                             done,
    output logic [bfl_pkg::NEED_W-1:0]       need
);

    localparam int NW = bfl_pkg::NEED_W;
    localparam int L  = $clog2(ALIGN_BYTES);
    localparam int SH = NW + L;
    localparam int MW = NW + 1;
    localparam int KW = L + 1;
    // Rounded-up reciprocal of the alignment, exact for any biased size below 2^NW
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [MW-1:0] M_C  = MW'(RECIP);
    localparam logic [KW-1:0] K_C  = KW'(ALIGN_BYTES);
    localparam logic [NW-1:0] BIAS = NW'(ALIGN_BYTES - 1);

    logic              v1_reg;
    logic              v2_reg;
    logic              done_reg;
    logic [NW-1:0]     x_reg;
    logic [NW-1:0]     q_reg;
    logic [NW-1:0]     need_reg;
    logic [NW+MW-1:0]  prod;
    logic [NW+KW-1:0]  mult;

    // Quotient of the biased size, then back to bytes, one multiply per cycle
    assign prod = (NW + MW)'(x_reg) * (NW + MW)'(M_C);
    assign mult = (NW + KW)'(q_reg) * (NW + KW)'(K_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= NW'(size) + BIAS;
        end
        if (v1_reg)
        begin
            q_reg <= NW'(prod >> SH);
        end
        if (v2_reg)
        begin
            need_reg <= mult[NW-1:0];
        end
    end

    assign need = need_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/bfl_pool_mem.sv -----
// Slot pool memory: one write and one registered read per cycle.
`default_nettype none

module bfl_pool_mem #(
    parameter int POOL_DEPTH = bfl_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [$clog2(POOL_DEPTH)-1:0]  waddr,
    input  wire bfl_pkg::slot_t                 wdata,
    input  wire logic                           re,
    input  wire logic [$clog2(POOL_DEPTH)-1:0]  raddr,
    output bfl_pkg::slot_t                      rdata
);

    bfl_pkg::slot_t mem [POOL_DEPTH];
    bfl_pkg::slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/bfl_best_sel.sv -----
// Best-fit tracker: compares each slot read from the pool against the best so far.
`default_nettype none

module bfl_best_sel #(
    parameter int POOL_DEPTH = bfl_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bfl_pkg::scan_ctl_t             ctl,
    input  wire logic [$clog2(POOL_DEPTH)-1:0]  raddr,
    input  wire bfl_pkg::slot_t                 rdata,
    input  wire logic [bfl_pkg::NEED_W-1:0]     need,
    input  wire logic [bfl_pkg::STEP_W-1:0]     first_step,
    output logic                                found,
    output logic [$clog2(POOL_DEPTH)-1:0]       best_idx,
    output logic [bfl_pkg::OFS_W-1:0]           best_ofs
);

    localparam int AW = $clog2(POOL_DEPTH);

    logic                        vld_reg;
    logic [AW-1:0]               idx_reg;
    logic                        found_reg;
    logic [AW-1:0]               best_idx_reg;
    logic [bfl_pkg::NEED_W-1:0]  best_size_reg;
    logic [bfl_pkg::OFS_W-1:0]   best_ofs_reg;
    logic                        hit;

    // Strictly smaller wins, so the earliest slot keeps a size tie
    assign hit = vld_reg && (rdata.freed < first_step) && (rdata.size >= need) &&
                 (!found_reg || (rdata.size < best_size_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= ctl.issue;
            if (hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= raddr;
        if (hit)
        begin
            best_idx_reg  <= idx_reg;
            best_size_reg <= rdata.size;
            best_ofs_reg  <= rdata.ofs;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best_ofs = best_ofs_reg;

endmodule

`default_nettype wire

// ----- rtl/bfl_checker.sv -----
// Port-level checker for the planner, bound to its top level.
`default_nettype none
`include "best_fit_lifetime_buffer_planner_macros.svh"

module bfl_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [bfl_pkg::OFS_W-1:0]   offset,
    input wire logic                        reused,
    input wire logic [bfl_pkg::OFS_W-1:0]   region_top,
    input wire logic                        rejected
);

    `BFL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(offset) && $stable(region_top) && $stable(rejected), "stalled result changed")
    `BFL_ASSERT_NOW(a_rej_clean, out_valid && rejected, (offset == '0) && !reused, "rejected result carries a placement")
    `BFL_ASSERT_NOW(a_ofs_in_region, out_valid && !rejected, offset <= region_top, "placement offset beyond high-water mark")
    `BFL_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "second transfer taken while an item is in work")

endmodule

bind best_fit_lifetime_buffer_planner bfl_checker u_bfl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (lifetime.valid),
    .in_ready   (lifetime.ready),
    .out_valid  (placement.valid),
    .out_ready  (placement.ready),
    .offset     (placement.offset),
    .reused     (placement.reused),
    .region_top (placement.region_bytes),
    .rejected   (placement.rejected)
);

`default_nettype wire
